FILE: rtl/golden_ratio_hsv_color_gen_unit_macros.svh
// ----------------------------------------------------------------------------
// golden ratio hsv colour generator - assertion macros
// concurrent checks clocked on aclk, disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef GOLDEN_RATIO_HSV_COLOR_GEN_UNIT_MACROS_SVH
`define GOLDEN_RATIO_HSV_COLOR_GEN_UNIT_MACROS_SVH

// same-cycle implication
`define GR_HSV_ASSERT_NOW(label, ant, con, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (con)) \
        else $error(msg);

// next-cycle implication
`define GR_HSV_ASSERT_NEXT(label, ant, con, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (con)) \
        else $error(msg);

`endif

FILE: rtl/gr_hsv_pkg.sv
// ----------------------------------------------------------------------------
// gr_hsv_pkg
// shared constants, command codes and queue status for the hsv colour unit
// ----------------------------------------------------------------------------
package gr_hsv_pkg;

    localparam int HUE_BITS_DEFAULT = 16;
    localparam int LEVEL_FRAC_BITS  = 8;
    localparam int LEVEL_W          = LEVEL_FRAC_BITS + 1;
    localparam int HUE_IN_W         = 16;
    localparam int HUE_OUT_W        = 16;
    localparam int CHAN_W           = 8;
    localparam int QUEUE_DEPTH      = 2;

    // golden-ratio fraction, top bits taken for the hue width
    localparam logic [63:0] GOLDEN_FRAC = 64'h9E3779B97F4A7C15;

    typedef enum logic [1:0] {
        CMD_CONVERT = 2'd0,
        CMD_STEP    = 2'd1,
        CMD_SEED    = 2'd2,
        CMD_UNUSED  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

FILE: rtl/gr_hsv_front.sv
// ----------------------------------------------------------------------------
// gr_hsv_front
// takes commands, keeps the hue accumulator and queues conversion jobs
// ----------------------------------------------------------------------------
module gr_hsv_front #(
    parameter int HUE_BITS = gr_hsv_pkg::HUE_BITS_DEFAULT
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  logic [1:0]                                  in_cmd,
    input  logic [gr_hsv_pkg::HUE_IN_W-1:0]             in_hue,
    input  logic [gr_hsv_pkg::LEVEL_W-1:0]              in_sat,
    input  logic [gr_hsv_pkg::LEVEL_W-1:0]              in_val,
    input  logic                                        job_ready,
    output logic                                        job_push,
    output logic [HUE_BITS+2*gr_hsv_pkg::LEVEL_W-1:0]   job_data
);

    localparam int LW = gr_hsv_pkg::LEVEL_W;
    localparam logic [LW-1:0] LEVEL_ONE = LW'(1) << gr_hsv_pkg::LEVEL_FRAC_BITS;
    localparam logic [HUE_BITS-1:0] GOLDEN_STEP =
        HUE_BITS'(gr_hsv_pkg::GOLDEN_FRAC >> (64 - HUE_BITS));

    logic [HUE_BITS-1:0]                         acc_reg, acc_next;
    logic [HUE_BITS-1:0]                         acc_step;
    logic [HUE_BITS-1:0]                         hue_masked;
    logic [HUE_BITS+gr_hsv_pkg::HUE_IN_W-1:0]    hue_wide;
    logic [HUE_BITS-1:0]                         job_hue;
    logic [LW-1:0]                               sat_c, val_c;
    logic                                        accept;

    assign in_ready   = job_ready;
    assign accept     = in_valid && in_ready;
    assign hue_wide   = {{HUE_BITS{1'b0}}, in_hue};
    assign hue_masked = hue_wide[HUE_BITS-1:0];
    assign acc_step   = acc_reg + GOLDEN_STEP;
    assign sat_c      = (in_sat > LEVEL_ONE) ? LEVEL_ONE : in_sat;
    assign val_c      = (in_val > LEVEL_ONE) ? LEVEL_ONE : in_val;
    assign job_data   = {val_c, sat_c, job_hue};

    always_comb begin
        acc_next = acc_reg;
        job_push = 1'b0;
        job_hue  = hue_masked;
        if (accept) begin
            unique case (in_cmd)
                gr_hsv_pkg::CMD_CONVERT: begin
                    job_push = 1'b1;
                end
                gr_hsv_pkg::CMD_STEP: begin
                    acc_next = acc_step;
                    job_hue  = acc_step;
                    job_push = 1'b1;
                end
                gr_hsv_pkg::CMD_SEED: begin
                    acc_next = hue_masked;
                end
                default: begin
                    // unused command, dropped
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

endmodule

FILE: rtl/gr_hsv_queue.sv
// ----------------------------------------------------------------------------
// gr_hsv_queue
// short job queue between the command front and the conversion pipeline
// ----------------------------------------------------------------------------
module gr_hsv_queue #(
    parameter int WIDTH = 34,
    parameter int DEPTH = gr_hsv_pkg::QUEUE_DEPTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push,
    input  logic [WIDTH-1:0]            push_data,
    input  logic                        pop,
    output logic                        pop_valid,
    output logic [WIDTH-1:0]            pop_data,
    output gr_hsv_pkg::queue_status_t   status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_valid    = !status.empty;
    assign pop_data     = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/gr_hsv_back.sv
// ----------------------------------------------------------------------------
// gr_hsv_back
// two-stage hsv to rgb pipeline with registered result
// ----------------------------------------------------------------------------
module gr_hsv_back #(
    parameter int HUE_BITS = gr_hsv_pkg::HUE_BITS_DEFAULT
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  logic [HUE_BITS+2*gr_hsv_pkg::LEVEL_W-1:0]   in_job,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic [3*gr_hsv_pkg::CHAN_W+gr_hsv_pkg::HUE_OUT_W-1:0] out_data
);

    localparam int LW  = gr_hsv_pkg::LEVEL_W;
    localparam int FB  = gr_hsv_pkg::LEVEL_FRAC_BITS;
    localparam int CW  = gr_hsv_pkg::CHAN_W;
    localparam int HOW = gr_hsv_pkg::HUE_OUT_W;
    localparam int PW  = HUE_BITS + LW;        // f*s and (1-f)*s products
    localparam int MW  = PW + LW;              // v*(full - x*s)
    localparam int CPW = 2 * LW;               // v*(1-s)
    localparam logic [LW-1:0] LEVEL_ONE = LW'(1) << FB;
    localparam logic [PW-1:0] FULL      = PW'(1) << (HUE_BITS + FB);

    function automatic logic [CW-1:0] sat_chan(input logic [LW-1:0] x);
        return x[LW-1] ? {CW{1'b1}} : x[CW-1:0];
    endfunction

    // job fields
    logic [HUE_BITS-1:0]     j_hue;
    logic [LW-1:0]           j_sat, j_val;
    logic [HUE_BITS+2:0]     six;
    logic [HUE_BITS-1:0]     frac;
    logic [HUE_BITS:0]       frac_inv;
    logic [PW-1:0]           fs, gs;
    logic [CPW-1:0]          cp_prod;
    logic [HUE_BITS+HOW-1:0] hue_wide;

    // stage 1
    logic                    s1_v_reg, s1_v_next;
    logic [2:0]              s1_sext_reg;
    logic [PW-1:0]           s1_fs_reg, s1_gs_reg;
    logic [CW-1:0]           s1_cp_reg, s1_cv_reg;
    logic [LW-1:0]           s1_val_reg;
    logic [HOW-1:0]          s1_hue_reg;
    logic                    s1_ready, s1_load;

    // stage 2 / result
    logic                    out_v_reg, out_v_next;
    logic [MW-1:0]           mq, mt;
    logic [CW-1:0]           cq, ct;
    logic [CW-1:0]           r_sel, g_sel, b_sel;
    logic [CW-1:0]           r_reg, g_reg, b_reg;
    logic [HOW-1:0]          hue_out_reg;
    logic                    out_adv, out_load;

    assign {j_val, j_sat, j_hue} = in_job;

    // hue*6 as shift-add, top bits give the sextant
    assign six      = {1'b0, j_hue, 2'b00} + {2'b00, j_hue, 1'b0};
    assign frac     = six[HUE_BITS-1:0];
    assign frac_inv = {1'b1, {HUE_BITS{1'b0}}} - {1'b0, frac};
    assign fs       = PW'(frac) * PW'(j_sat);
    assign gs       = PW'(frac_inv) * PW'(j_sat);
    assign cp_prod  = CPW'(j_val) * CPW'(LEVEL_ONE - j_sat);
    assign hue_wide = {{HOW{1'b0}}, j_hue};

    assign out_adv   = !out_v_reg || out_ready;
    assign s1_ready  = !s1_v_reg || out_adv;
    assign in_ready  = s1_ready;
    assign s1_load   = in_valid && s1_ready;
    assign s1_v_next = s1_ready ? in_valid : s1_v_reg;
    assign out_load  = s1_v_reg && out_adv;
    assign out_v_next = out_adv ? s1_v_reg : out_v_reg;

    assign mq = MW'(s1_val_reg) * MW'(FULL - s1_fs_reg);
    assign mt = MW'(s1_val_reg) * MW'(FULL - s1_gs_reg);
    assign cq = sat_chan(mq[HUE_BITS+FB+LW-1:HUE_BITS+FB]);
    assign ct = sat_chan(mt[HUE_BITS+FB+LW-1:HUE_BITS+FB]);

    always_comb begin
        unique case (s1_sext_reg)
            3'd0: begin
                r_sel = s1_cv_reg; g_sel = ct;        b_sel = s1_cp_reg;
            end
            3'd1: begin
                r_sel = cq;        g_sel = s1_cv_reg; b_sel = s1_cp_reg;
            end
            3'd2: begin
                r_sel = s1_cp_reg; g_sel = s1_cv_reg; b_sel = ct;
            end
            3'd3: begin
                r_sel = s1_cp_reg; g_sel = cq;        b_sel = s1_cv_reg;
            end
            3'd4: begin
                r_sel = ct;        g_sel = s1_cp_reg; b_sel = s1_cv_reg;
            end
            default: begin
                r_sel = s1_cv_reg; g_sel = s1_cp_reg; b_sel = cq;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            s1_v_reg  <= s1_v_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_load) begin
            s1_sext_reg <= six[HUE_BITS+2:HUE_BITS];
            s1_fs_reg   <= fs;
            s1_gs_reg   <= gs;
            s1_cp_reg   <= sat_chan(cp_prod[FB+LW-1:FB]);
            s1_cv_reg   <= sat_chan(j_val);
            s1_val_reg  <= j_val;
            s1_hue_reg  <= hue_wide[HOW-1:0];
        end
        if (out_load) begin
            r_reg       <= r_sel;
            g_reg       <= g_sel;
            b_reg       <= b_sel;
            hue_out_reg <= s1_hue_reg;
        end
    end

    assign out_valid = out_v_reg;
    assign out_data  = {hue_out_reg, b_reg, g_reg, r_reg};

endmodule

FILE: rtl/golden_ratio_hsv_color_gen_unit.sv
// accepted convert or step jobs pass the job queue, stage 1 and the result registers
// throughput: one item per cycle unless m_tready low or queue full; front hue add is comb
// the two-entry job queue and the two pipeline registers in the back set the latency
// seed commands and unused commands give no result and take one transfer slot each
// reset (aresetn low, synchronous) clears the hue accumulator, the queue and all valid flags
// ----------------------------------------------------------------------------
// golden_ratio_hsv_color_gen_unit
// hsv to rgb colour generator with golden-ratio hue stepping
// ----------------------------------------------------------------------------
`include "golden_ratio_hsv_color_gen_unit_macros.svh"

module golden_ratio_hsv_color_gen_unit #(
    parameter int HUE_BITS = gr_hsv_pkg::HUE_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // hue_in[15:0], saturation[24:16], value_level[33:25]
    input  logic [1:0]  s_tuser,    // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata     // red[7:0], green[15:8], blue[23:16], hue_used[39:24]
);

    localparam int LW    = gr_hsv_pkg::LEVEL_W;
    localparam int HIW   = gr_hsv_pkg::HUE_IN_W;
    localparam int JOB_W = HUE_BITS + 2 * LW;

    logic                          job_push, job_ready;
    logic [JOB_W-1:0]              job_data;
    logic                          q_valid, q_pop;
    logic [JOB_W-1:0]              q_data;
    gr_hsv_pkg::queue_status_t     q_status;

    assign job_ready = !q_status.full;

    gr_hsv_front #(
        .HUE_BITS (HUE_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_hue    (s_tdata[HIW-1:0]),
        .in_sat    (s_tdata[HIW+LW-1:HIW]),
        .in_val    (s_tdata[HIW+2*LW-1:HIW+LW]),
        .job_ready (job_ready),
        .job_push  (job_push),
        .job_data  (job_data)
    );

    gr_hsv_queue #(
        .WIDTH (JOB_W),
        .DEPTH (gr_hsv_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_data (job_data),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_data),
        .status    (q_status)
    );

    gr_hsv_back #(
        .HUE_BITS (HUE_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_valid),
        .in_ready  (q_pop),
        .in_job    (q_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    `GR_HSV_ASSERT_NOW(a_no_job_for_seed,
        s_tvalid && s_tready && (s_tuser == gr_hsv_pkg::CMD_SEED || s_tuser == gr_hsv_pkg::CMD_UNUSED),
        !job_push, "seed or unused command queued a job")

    `GR_HSV_ASSERT_NOW(a_push_needs_transfer, job_push,
        s_tvalid && s_tready, "job queued without an input transfer")

    `GR_HSV_ASSERT_NOW(a_full_blocks_input, q_status.full, !s_tready,
        "input ready while job queue full")

    `GR_HSV_ASSERT_NEXT(a_push_fills_queue, job_push && q_status.empty,
        !q_status.empty, "queued job lost")

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - golden ratio hsv colour generator testbench
// drives convert, step, seed and unused commands through the input stream,
// predicts every colour with its own fixed-point hsv model and hue accumulator,
// and compares each result transfer field by field in arrival order
// ----------------------------------------------------------------------------
module tb;
    import gr_hsv_pkg::*;

    localparam logic [63:0] GOLDEN_WIDE  = GOLDEN_FRAC >> 48;
    localparam logic [15:0] GOLDEN_STEP  = GOLDEN_WIDE[15:0];
    localparam int          RANDOM_ITEMS = 1450;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          SETTLE_CYCLES = 20;

    typedef struct {
        logic [1:0]  cmd;
        logic [15:0] hue;
        logic [8:0]  sat;
        logic [8:0]  val;
        bit          drain;   // hold off until every pending colour has come back
    } hsv_req_t;

    typedef struct {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] hue_used;
    } hsv_colour_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // hue_in[15:0], saturation[24:16], value_level[33:25]
    logic [1:0]  s_tuser = '0;   // cmd[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // red[7:0], green[15:8], blue[23:16], hue_used[39:24]

    hsv_req_t    pending_reqs[$];
    hsv_colour_t expected_colours[$];
    hsv_req_t    cur_req;
    logic [15:0] golden_hue_acc = '0;
    int          err_count = 0;
    int          cycle_count = 0;
    int          burst_left = 1;
    int          gap_left = 0;
    int          stall_mode = 0;
    int          mode_left = 0;

    golden_ratio_hsv_color_gen_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [63:0] clamp_level(input logic [8:0] raw);
        return (raw > 9'd256) ? 64'd256 : {55'd0, raw};
    endfunction

    function automatic logic [7:0] sat_chan(input logic [63:0] x);
        return (x > 64'd255) ? 8'd255 : x[7:0];
    endfunction

    // six-sextant hsv, all floors taken on exact products
    function automatic hsv_colour_t hsv_to_rgb(input logic [15:0] hue, input logic [8:0] sat_raw,
                                               input logic [8:0] val_raw);
        logic [63:0] s, v, six, f, full;
        logic [7:0]  cv, cp, cq, ct;
        hsv_colour_t c;
        s    = clamp_level(sat_raw);
        v    = clamp_level(val_raw);
        six  = {48'd0, hue} * 64'd6;
        f    = six & 64'hFFFF;
        full = 64'd1 << 24;
        cv   = sat_chan(v);
        cp   = sat_chan((v * (64'd256 - s)) >> 8);
        cq   = sat_chan((v * (full - f * s)) >> 24);
        ct   = sat_chan((v * (full - (64'd65536 - f) * s)) >> 24);
        case (six >> 16)
            0:       begin c.red = cv; c.green = ct; c.blue = cp; end
            1:       begin c.red = cq; c.green = cv; c.blue = cp; end
            2:       begin c.red = cp; c.green = cv; c.blue = ct; end
            3:       begin c.red = cp; c.green = cq; c.blue = cv; end
            4:       begin c.red = ct; c.green = cp; c.blue = cv; end
            default: begin c.red = cv; c.green = cp; c.blue = cq; end
        endcase
        c.hue_used = hue;
        return c;
    endfunction

    task automatic apply_request(input hsv_req_t req);
        case (req.cmd)
            CMD_CONVERT: expected_colours.push_back(hsv_to_rgb(req.hue, req.sat, req.val));
            CMD_STEP: begin
                golden_hue_acc = golden_hue_acc + GOLDEN_STEP;
                expected_colours.push_back(hsv_to_rgb(golden_hue_acc, req.sat, req.val));
            end
            CMD_SEED: golden_hue_acc = req.hue;
            default: ;
        endcase
    endtask

    task automatic add_req(input logic [1:0] cmd, input logic [15:0] hue,
                           input logic [8:0] sat, input logic [8:0] val, input bit drain);
        hsv_req_t r;
        r.cmd   = cmd;
        r.hue   = hue;
        r.sat   = sat;
        r.val   = val;
        r.drain = drain;
        pending_reqs.push_back(r);
    endtask

    // levels weighted towards zero, one and the clamped range above one
    function automatic logic [8:0] rand_level();
        case ($urandom_range(0, 9))
            0:       return 9'd0;
            1:       return 9'd256;
            2:       return 9'($urandom_range(257, 511));
            3:       return 9'd255;
            default: return 9'($urandom_range(0, 256));
        endcase
    endfunction

    // sender: bursts of random length separated by random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end else begin
            if (s_tvalid && s_tready)
                apply_request(cur_req);
            if (s_tvalid && !s_tready) begin
                // hold the current transfer
            end else if (gap_left != 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() == 0 ||
                         (pending_reqs[0].drain && expected_colours.size() != 0)) begin
                s_tvalid <= 1'b0;
            end else begin
                cur_req  = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {6'd0, cur_req.val, cur_req.sat, cur_req.hue};
                s_tuser  <= cur_req.cmd;
                if (burst_left <= 1) begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                             : $urandom_range(1, 20);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // receiver: stall mode is redrawn whenever its mode counter runs out
    always @(posedge aclk) begin
        hsv_colour_t exp_c;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_colours.size() == 0) begin
                    $error("unexpected result transfer: %h", m_tdata);
                    err_count++;
                end else begin
                    exp_c = expected_colours.pop_front();
                    if (m_tdata[7:0] !== exp_c.red) begin
                        $error("red: expected %0d, actual %0d", exp_c.red, m_tdata[7:0]);
                        err_count++;
                    end
                    if (m_tdata[15:8] !== exp_c.green) begin
                        $error("green: expected %0d, actual %0d", exp_c.green, m_tdata[15:8]);
                        err_count++;
                    end
                    if (m_tdata[23:16] !== exp_c.blue) begin
                        $error("blue: expected %0d, actual %0d", exp_c.blue, m_tdata[23:16]);
                        err_count++;
                    end
                    if (m_tdata[39:24] !== exp_c.hue_used) begin
                        $error("hue_used: expected %h, actual %h", exp_c.hue_used,
                               m_tdata[39:24]);
                        err_count++;
                    end
                end
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(30, 200);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= (cycle_count % 4 == 0);
                default: m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    initial begin
        int          counted;
        int          run_len;
        logic [1:0]  cmd;

        // directed: hue extremes and sextant edges, level extremes, accumulator wrap
        add_req(CMD_STEP,    16'h0000, 9'd256, 9'd256, 1'b0);  // first step from reset
        add_req(CMD_CONVERT, 16'h0000, 9'd0,   9'd256, 1'b0);  // full level saturates
        add_req(CMD_CONVERT, 16'hFFFF, 9'd256, 9'd256, 1'b0);
        add_req(CMD_CONVERT, 16'h2AAA, 9'd256, 9'd256, 1'b0);
        add_req(CMD_CONVERT, 16'h2AAB, 9'd256, 9'd256, 1'b0);
        add_req(CMD_CONVERT, 16'h5555, 9'd128, 9'd200, 1'b0);
        add_req(CMD_CONVERT, 16'h5556, 9'd128, 9'd200, 1'b0);
        add_req(CMD_CONVERT, 16'h8000, 9'd511, 9'd511, 1'b0);  // clamped above one
        add_req(CMD_CONVERT, 16'hAAAA, 9'd300, 9'd100, 1'b0);
        add_req(CMD_CONVERT, 16'hAAAB, 9'd1,   9'd255, 1'b0);
        add_req(CMD_CONVERT, 16'hD555, 9'd256, 9'd0,   1'b0);
        add_req(CMD_CONVERT, 16'hD556, 9'd0,   9'd0,   1'b0);
        add_req(CMD_CONVERT, 16'h1234, 9'd257, 9'd257, 1'b0);
        add_req(CMD_UNUSED,  16'hFFFF, 9'd511, 9'd511, 1'b0);  // no result, no state change
        add_req(CMD_STEP,    16'hFFFF, 9'd0,   9'd256, 1'b0);
        add_req(CMD_SEED,    16'hFFFF, 9'd0,   9'd0,   1'b0);
        add_req(CMD_STEP,    16'h0000, 9'd256, 9'd256, 1'b0);  // wraps modulo one
        add_req(CMD_STEP,    16'h0000, 9'd255, 9'd511, 1'b0);
        add_req(CMD_SEED,    16'h0000, 9'd511, 9'd511, 1'b1);
        add_req(CMD_STEP,    16'h0000, 9'd100, 9'd256, 1'b0);
        add_req(CMD_UNUSED,  16'h0000, 9'd0,   9'd0,   1'b0);
        add_req(CMD_STEP,    16'h0000, 9'd200, 9'd50,  1'b0);

        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    // seed then a run of golden steps
                    add_req(CMD_SEED, 16'($urandom), rand_level(), rand_level(),
                            counted == 0 || $urandom_range(0, 99) == 0);
                    run_len = $urandom_range(1, 12);
                    repeat (run_len)
                        add_req(CMD_STEP, 16'($urandom), rand_level(), rand_level(), 1'b0);
                    counted += run_len + 1;
                end
                4, 5, 6: begin
                    run_len = $urandom_range(1, 8);
                    repeat (run_len)
                        add_req(CMD_CONVERT, 16'($urandom), rand_level(), rand_level(), 1'b0);
                    counted += run_len;
                end
                7: begin
                    add_req(CMD_UNUSED, 16'($urandom), 9'($urandom), 9'($urandom), 1'b0);
                end
                default: begin
                    cmd = 2'($urandom_range(0, 3));
                    add_req(cmd, 16'($urandom), 9'($urandom), 9'($urandom), 1'b0);
                    if (cmd != CMD_UNUSED)
                        counted++;
                end
            endcase
        end

        while (pending_reqs.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (expected_colours.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
